@@ src/blist_pkg.sv @@
// ----------------------------------------------------------------------------
// blist_pkg
// Shared types and constants for the bounded ordered list and its cells.
// ----------------------------------------------------------------------------
package blist_pkg;

    // Wide enough for any index or count up to the largest supported capacity.
    localparam int IDX_W = 11;
    localparam int VAL_W = 32;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_READ   = 3'd2,
        REQ_SEARCH = 3'd3,
        REQ_INSERT = 3'd4
    } t_req;

    // Operation broadcast to every cell.
    typedef struct packed {
        logic             ins;      // one-cycle write strobe
        logic [IDX_W-1:0] ins_pos;
        logic [IDX_W-1:0] lim;      // element count before the request
        logic             search;   // 1: match on key, 0: match on target
        logic [IDX_W-1:0] target;
        logic [VAL_W-1:0] key;      // search key or value to insert
    } t_op;

    // Result token walking down the chain.
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] pos;
    } t_tok;

endpackage

@@ src/blist_cell.sv @@
// ----------------------------------------------------------------------------
// blist_cell
// One list slot: holds an element, takes its left neighbor's element on an
// insert shift, and passes the result token to the right, capturing it on
// the first hit.
// ----------------------------------------------------------------------------
module blist_cell #(
    parameter int INDEX = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  blist_pkg::t_op                  i_op,
    input  logic [blist_pkg::VAL_W-1:0]     i_left_data,
    output logic [blist_pkg::VAL_W-1:0]     o_data,
    input  blist_pkg::t_tok                 i_tok,
    output blist_pkg::t_tok                 o_tok
);
    import blist_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [VAL_W-1:0] r_data;
    t_tok             r_tok;
    t_tok             n_tok;
    logic             w_hit;

    always_ff @(posedge i_clk) begin
        if (i_op.ins) begin
            if (MY_IDX == i_op.ins_pos) begin
                r_data <= i_op.key;
            end else if (MY_IDX > i_op.ins_pos && MY_IDX <= i_op.lim) begin
                r_data <= i_left_data;
            end
        end
    end

    assign w_hit = i_op.search ? (r_data == i_op.key && MY_IDX < i_op.lim)
                               : (MY_IDX == i_op.target);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && !i_tok.hit && w_hit) begin
            n_tok.hit   = 1'b1;
            n_tok.value = r_data;
            n_tok.pos   = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.hit   <= n_tok.hit;
        r_tok.value <= n_tok.value;
        r_tok.pos   <= n_tok.pos;
    end

    assign o_data = r_data;
    assign o_tok  = r_tok;

endmodule

@@ src/bounded_ordered_list.sv @@
// ----------------------------------------------------------------------------
// bounded_ordered_list
// Ordered list of signed 32-bit values built as a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one request: req_type, value,
//   position. Output channel (o_valid/i_ready) returns one result per
//   request: ok, result_value, found_position, element_count.
//   One request is in flight at a time; o_ready is high while the
//   controller is idle.
//   Append, insert, unknown requests, and a read, remove or search that is
//   refused up front (bad position, empty list): the result goes to the
//   pending registers, then from S_FIN into the output register.
//   Other reads, removes and searches: a token walks the whole cell chain,
//   one cell per cycle, then the result goes to the pending registers and
//   from S_FIN into the output register. The chain length sets the walk time.
//   A new request is accepted only once the controller is back in idle.
//   The result sits in an output register; a new request is accepted while
//   it waits. If the receiver stalls, a finished second result waits in
//   the controller until the output register frees up.
//   Reset empties the list (count to zero); cell contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_ordered_list #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_value,
    input  logic [6:0]  i_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic [31:0] o_result_value,
    output logic [5:0]  o_found_position,
    output logic [6:0]  o_element_count
);
    import blist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    t_op                r_op, n_op;
    logic               r_launch, n_launch;
    logic               r_p_ok, n_p_ok;
    logic [VAL_W-1:0]   r_p_val, n_p_val;
    logic [5:0]         r_p_pos, n_p_pos;
    logic               r_o_valid, n_o_valid;
    logic               r_o_ok, n_o_ok;
    logic [VAL_W-1:0]   r_o_val, n_o_val;
    logic [5:0]         r_o_pos, n_o_pos;
    logic [6:0]         r_o_cnt, n_o_cnt;

    logic [IDX_W-1:0]   w_cnt_x;
    logic [IDX_W-1:0]   w_pos_x;
    logic               w_room;

    logic [VAL_W-1:0]   w_data [CAPACITY];
    t_tok               w_tok  [CAPACITY+1];
    t_tok               w_last;

    // ---------------- cell chain ----------------
    assign w_tok[0] = '{vld: r_launch, hit: 1'b0, value: '0, pos: '0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_rest
            assign w_left = w_data[g-1];
        end
        blist_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (r_op),
            .i_left_data (w_left),
            .o_data      (w_data[g]),
            .i_tok       (w_tok[g]),
            .o_tok       (w_tok[g+1])
        );
    end

    assign w_last = w_tok[CAPACITY];

    // ---------------- controller ----------------
    assign w_cnt_x = IDX_W'(r_count);
    assign w_pos_x = IDX_W'(i_position);
    assign w_room  = r_count < CNT_W'(CAPACITY);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_op      = r_op;
        n_op.ins  = 1'b0;
        n_launch  = 1'b0;
        n_p_ok    = r_p_ok;
        n_p_val   = r_p_val;
        n_p_pos   = r_p_pos;
        n_o_valid = r_o_valid && !i_ready;
        n_o_ok    = r_o_ok;
        n_o_val   = r_o_val;
        n_o_pos   = r_o_pos;
        n_o_cnt   = r_o_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_p_ok    = 1'b0;
                    n_p_val   = '0;
                    n_p_pos   = '0;
                    n_state   = S_FIN;
                    n_op.key  = i_value;
                    n_op.lim  = w_cnt_x;
                    unique case (t_req'(i_req_type))
                        REQ_APPEND: begin
                            if (w_room) begin
                                n_op.ins     = 1'b1;
                                n_op.ins_pos = w_cnt_x;
                                n_count      = r_count + CNT_W'(1);
                                n_p_ok       = 1'b1;
                            end
                        end
                        REQ_INSERT: begin
                            if (w_room && w_pos_x <= w_cnt_x) begin
                                n_op.ins     = 1'b1;
                                n_op.ins_pos = w_pos_x;
                                n_count      = r_count + CNT_W'(1);
                                n_p_ok       = 1'b1;
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_count != '0) begin
                                n_op.search = 1'b0;
                                n_op.target = w_cnt_x - IDX_W'(1);
                                n_count     = r_count - CNT_W'(1);
                                n_launch    = 1'b1;
                                n_state     = S_WALK;
                            end
                        end
                        REQ_READ: begin
                            if (w_pos_x < w_cnt_x) begin
                                n_op.search = 1'b0;
                                n_op.target = w_pos_x;
                                n_launch    = 1'b1;
                                n_state     = S_WALK;
                            end
                        end
                        REQ_SEARCH: begin
                            if (r_count != '0) begin
                                n_op.search = 1'b1;
                                n_launch    = 1'b1;
                                n_state     = S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (w_last.vld) begin
                    n_p_ok  = w_last.hit;
                    n_p_val = r_op.search ? '0 : w_last.value;
                    n_p_pos = (r_op.search && w_last.hit) ? w_last.pos[5:0] : 6'd0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_ok    = r_p_ok;
                    n_o_val   = r_p_val;
                    n_o_pos   = r_p_pos;
                    n_o_cnt   = 7'(r_count);
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_op      <= '0;
            r_launch  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_op      <= n_op;
            r_launch  <= n_launch;
            r_o_valid <= n_o_valid;
        end
        r_p_ok  <= n_p_ok;
        r_p_val <= n_p_val;
        r_p_pos <= n_p_pos;
        r_o_ok  <= n_o_ok;
        r_o_val <= n_o_val;
        r_o_pos <= n_o_pos;
        r_o_cnt <= n_o_cnt;
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_ok             = r_o_ok;
    assign o_result_value   = r_o_val;
    assign o_found_position = r_o_pos;
    assign o_element_count  = r_o_cnt;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_tok_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.vld |-> r_state == S_WALK)
        else $error("token left the chain outside a walk");

    a_target_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && w_last.vld && !r_op.search) |-> w_last.hit)
        else $error("read or remove walk missed its target cell");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_state != S_IDLE)
        else $error("controller idle right after accepting a request");

    a_ins_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op.ins |-> (r_state == S_FIN && !r_launch))
        else $error("cell write outside the request that caused it");

endmodule
